// ----- src/bb3_pkg.sv -----
// Shared types, constants and helpers of the 3x3 box blur (top half).
package bb3_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 11;
    localparam int OUT_COL_W   = 10;
    localparam int ROWCNT_W    = 12;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int SUM_W       = 12;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 13'd4096;
    localparam logic [PIX_W-1:0]    ALPHA_VALUE  = 8'hFF;

    // floor(x / 9) == (x * 3641) >> 15 for every x below 2^15
    localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
    localparam int               DIV9_SHIFT = 15;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic                 first_col;
        logic                 top_clamp;
        logic                 emit_a;
        logic                 emit_b;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
    } meta_t;

    typedef struct packed {
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green;
        logic [PIX_W-1:0]     blue;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } res_t;

    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [2*SUM_W-1:0] p;
        p = (2*SUM_W)'(s) * (2*SUM_W)'(DIV9_MUL);
        return p[DIV9_SHIFT +: PIX_W];
    endfunction

endpackage

// ----- src/box_blur_3x3_top_half_top.sv -----
// Top level of the 3x3 box blur over the upper half of a raster RGB stream.
// Pixels enter one word per cycle on the s_ side in raster order while s_tready
// is high. Each is read against two line stores (the previous two rows),
// written back from the stage-1 registers, shifted into a 3x3 window, summed
// per channel and divided by nine (multiply by reciprocal). Results leave on
// the m_ side one row and one column behind the input, only for rows below
// height/2; alpha is always 255. The input at the last column of a filtered
// row yields a second word (the right-edge pixel), marked with m_tlast on the
// final word of each input. Throughput is one pixel per cycle unless m_tready
// stalls; an input that yields two words holds s_tready low until the first
// has left the two-word output buffer, which drains one word a cycle. Edges
// are clamped: row -1 repeats row 0, and the first and last columns repeat.
// Line store contents need no clearing after reset. Any write to image_width
// or image_height restarts the frame at row 0, column 0; write only while idle.
module box_blur_3x3_top_half_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // in: red [7:0], green [15:8], blue [23:16]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bb3_pkg::IN_TDATA_W-1:0]      s_tdata,
    // out: red [7:0], green [15:8], blue [23:16], alpha [31:24],
    //      row [42:32], col [52:43], zero [55:53]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bb3_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    // config: index 0 image_width, 1 image_height
    input  logic                                cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bb3_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int MW_W   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW   = (MW_W > WIDTH_W) ? MW_W : WIDTH_W;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]       col_count_reg;
    logic [ROWCNT_W-1:0] row_count_reg;

    logic [CMPW-1:0]     w_cmp;
    logic [CMPW-1:0]     w_sat;
    logic [CW-1:0]       last_col;
    logic [HEIGHT_W-1:0] h_eff;
    logic [HEIGHT_W-1:0] half_h;
    logic [HEIGHT_W-1:0] r_ext;
    logic                active;
    logic                at_last_col;
    logic                at_last_row;
    logic                cfg_hit;

    logic                adv;
    logic                accept;
    pixel_t              in_pix;
    meta_t               in_meta;

    logic                lb_valid;
    meta_t               lb_meta;
    pixel_t              col_top;
    pixel_t              col_mid;
    pixel_t              col_bot;

    logic                push_a;
    logic                push_b;
    res_t                res_a;
    res_t                res_b;
    res_t                out_res;

    // effective width 1..MAX_WIDTH, height 1..4096
    assign w_cmp    = CMPW'(width_reg);
    assign w_sat    = (w_cmp == '0) ? CMPW'(1)
                    : ((w_cmp > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : w_cmp);
    assign last_col = CW'(w_sat - CMPW'(1));
    assign h_eff    = (height_reg == '0) ? HEIGHT_W'(1)
                    : ((height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg);
    assign half_h   = h_eff >> 1;
    assign r_ext    = HEIGHT_W'(row_count_reg);

    assign active      = (row_count_reg != '0) && ((r_ext - HEIGHT_W'(1)) < half_h);
    assign at_last_col = (col_count_reg == last_col);
    assign at_last_row = ((r_ext + HEIGHT_W'(1)) >= h_eff);
    assign cfg_hit     = cfg_we && ((cfg_index == REG_IMAGE_WIDTH)
                                 || (cfg_index == REG_IMAGE_HEIGHT));

    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    assign in_pix = '{red:   s_tdata[7:0],
                      green: s_tdata[15:8],
                      blue:  s_tdata[23:16]};

    assign in_meta = '{first_col: (col_count_reg == '0),
                       top_clamp: (row_count_reg <= ROWCNT_W'(1)),
                       emit_a:    active && (col_count_reg != '0),
                       emit_b:    active && at_last_col,
                       row:       ROW_W'(row_count_reg - ROWCNT_W'(1)),
                       col:       OUT_COL_W'(col_count_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data[WIDTH_W-1:0];
            end
            if (cfg_we && cfg_index == REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data[HEIGHT_W-1:0];
            end

            if (cfg_hit)
            begin
                col_count_reg <= '0;
                row_count_reg <= '0;
            end
            else if (accept)
            begin
                if (at_last_col)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= at_last_row ? '0 : row_count_reg + ROWCNT_W'(1);
                end
                else
                begin
                    col_count_reg <= col_count_reg + CW'(1);
                end
            end
        end
    end

    bb3_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (accept),
        .in_addr   (col_count_reg),
        .in_pix    (in_pix),
        .in_meta   (in_meta),
        .out_valid (lb_valid),
        .out_meta  (lb_meta),
        .col_top   (col_top),
        .col_mid   (col_mid),
        .col_bot   (col_bot)
    );

    bb3_filter u_filter (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (lb_valid),
        .in_meta  (lb_meta),
        .col_top  (col_top),
        .col_mid  (col_mid),
        .col_bot  (col_bot),
        .push_a   (push_a),
        .push_b   (push_b),
        .res_a    (res_a),
        .res_b    (res_b)
    );

    bb3_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .push_b    (push_b),
        .res_a     (res_a),
        .res_b     (res_b),
        .free      (adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'b000, out_res.col, out_res.row, ALPHA_VALUE,
                      out_res.blue, out_res.green, out_res.red};
    assign m_tlast = out_res.last;

    // column counter never runs past the last column of the current width
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_count_reg <= last_col)
        else $error("column counter beyond row width");

    // row counter wraps before the effective height
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_ext < h_eff)
        else $error("row counter beyond image height");

    // the second word of a pair is ready right after the first is taken
    a_pair_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("second word of a pair not presented");

endmodule

// ----- src/bb3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/bb3_line_buf.sv -----
// Two line stores: read at accept, write back from the stage-1 registers, with forwarding.
module bb3_line_buf #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] in_addr,
    input  bb3_pkg::pixel_t              in_pix,
    input  bb3_pkg::meta_t               in_meta,
    output logic                         out_valid,
    output bb3_pkg::meta_t               out_meta,
    output bb3_pkg::pixel_t              col_top,
    output bb3_pkg::pixel_t              col_mid,
    output bb3_pkg::pixel_t              col_bot
);
    import bb3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic          s1_valid_reg;
    logic [AW-1:0] s1_addr_reg;
    pixel_t        s1_pix_reg;
    meta_t         s1_meta_reg;
    logic          fwd_reg;
    pixel_t        fwd_prev_reg;
    pixel_t        fwd_prev2_reg;

    pixel_t        prev_q;
    pixel_t        prev2_q;
    pixel_t        mid;
    pixel_t        older;
    logic          wr;

    assign wr    = adv && s1_valid_reg;
    assign mid   = fwd_reg ? fwd_prev_reg : prev_q;
    assign older = fwd_reg ? fwd_prev2_reg : prev2_q;

    bb3_ram #(.WIDTH($bits(pixel_t)), .DEPTH(MAX_WIDTH)) u_prev (
        .clk   (clk),
        .we    (wr),
        .waddr (s1_addr_reg),
        .wdata (s1_pix_reg),
        .re    (in_valid),
        .raddr (in_addr),
        .rdata (prev_q)
    );

    bb3_ram #(.WIDTH($bits(pixel_t)), .DEPTH(MAX_WIDTH)) u_prev2 (
        .clk   (clk),
        .we    (wr),
        .waddr (s1_addr_reg),
        .wdata (mid),
        .re    (in_valid),
        .raddr (in_addr),
        .rdata (prev2_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= in_valid;
            end
            // RAM reads old data when the same column is written in that cycle
            if (in_valid)
            begin
                fwd_reg <= wr && (s1_addr_reg == in_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_addr_reg   <= in_addr;
            s1_pix_reg    <= in_pix;
            s1_meta_reg   <= in_meta;
            fwd_prev_reg  <= s1_pix_reg;
            fwd_prev2_reg <= mid;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_meta  = s1_meta_reg;
    assign col_mid   = mid;
    assign col_top   = s1_meta_reg.top_clamp ? mid : older;
    assign col_bot   = s1_pix_reg;

endmodule

// ----- src/bb3_filter.sv -----
// 3x3 window, per-channel sums and divide by nine for both candidate results.
module bb3_filter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  bb3_pkg::meta_t  in_meta,
    input  bb3_pkg::pixel_t col_top,
    input  bb3_pkg::pixel_t col_mid,
    input  bb3_pkg::pixel_t col_bot,
    output logic            push_a,
    output logic            push_b,
    output bb3_pkg::res_t   res_a,
    output bb3_pkg::res_t   res_b
);
    import bb3_pkg::*;

    // win_reg[x][y]: column x (0 oldest), row y (0 top)
    pixel_t           win_reg [3][3];
    logic             s2_valid_reg;
    meta_t            s2_meta_reg;
    logic             s3_valid_reg;
    meta_t            s3_meta_reg;
    logic [SUM_W-1:0] s3_sum_a_reg [3];
    logic [SUM_W-1:0] s3_sum_b_reg [3];

    logic [SUM_W-1:0] col_sum [3][3];   // [column][channel]
    logic [SUM_W-1:0] sum_a   [3];
    logic [SUM_W-1:0] sum_b   [3];
    logic [PIX_W-1:0] q_a     [3];
    logic [PIX_W-1:0] q_b     [3];
    pixel_t           new_col [3];

    assign new_col[0] = col_top;
    assign new_col[1] = col_mid;
    assign new_col[2] = col_bot;

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            for (int y = 0; y < 3; y++)
            begin
                // first column of a row fills the whole window
                for (int x = 0; x < 2; x++)
                begin
                    win_reg[x][y] <= in_meta.first_col ? new_col[y] : win_reg[x+1][y];
                end
                win_reg[2][y] <= new_col[y];
            end
        end
    end

    // channel k sits at bits [8k +: 8]: 0 blue, 1 green, 2 red
    always_comb
    begin
        for (int x = 0; x < 3; x++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                col_sum[x][k] = SUM_W'(win_reg[x][0][PIX_W*k +: PIX_W])
                              + SUM_W'(win_reg[x][1][PIX_W*k +: PIX_W])
                              + SUM_W'(win_reg[x][2][PIX_W*k +: PIX_W]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            sum_a[k] = col_sum[0][k] + col_sum[1][k] + col_sum[2][k];
            // flush at the right edge: last column repeated
            sum_b[k] = col_sum[1][k] + col_sum[2][k] + col_sum[2][k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_meta_reg  <= in_meta;
            s3_meta_reg  <= s2_meta_reg;
            s3_sum_a_reg <= sum_a;
            s3_sum_b_reg <= sum_b;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            q_a[k] = div9(s3_sum_a_reg[k]);
            q_b[k] = div9(s3_sum_b_reg[k]);
        end
    end

    assign push_a = s3_valid_reg && s3_meta_reg.emit_a;
    assign push_b = s3_valid_reg && s3_meta_reg.emit_b;

    assign res_a = '{red:   q_a[2],
                     green: q_a[1],
                     blue:  q_a[0],
                     row:   s3_meta_reg.row,
                     col:   s3_meta_reg.col - OUT_COL_W'(1),
                     last:  !s3_meta_reg.emit_b};

    assign res_b = '{red:   q_b[2],
                     green: q_b[1],
                     blue:  q_b[0],
                     row:   s3_meta_reg.row,
                     col:   s3_meta_reg.col,
                     last:  1'b1};

endmodule

// ----- src/bb3_out_buf.sv -----
// Two-word output buffer; drains a result pair, frees the pipeline when empty or when its last word is taken.
module bb3_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_a,
    input  logic          push_b,
    input  bb3_pkg::res_t res_a,
    input  bb3_pkg::res_t res_b,
    output logic          free,
    output logic          out_valid,
    input  logic          out_ready,
    output bb3_pkg::res_t out_res
);
    import bb3_pkg::*;

    logic [1:0] cnt_reg;
    res_t       slot0_reg;
    res_t       slot1_reg;
    logic       pop;

    assign pop  = (cnt_reg != 2'd0) && out_ready;
    assign free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (free)
        begin
            cnt_reg <= 2'(push_a) + 2'(push_b);
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free)
        begin
            slot0_reg <= push_a ? res_a : res_b;
            slot1_reg <= res_b;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = slot0_reg;

endmodule
